/* src/gaodg_pkg.sv */
// Shared types, codes and constants for the Gaussian orbital density grid block.
`default_nettype none

package gaodg_pkg;

    // Input item codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    // Fixed-point constants of the exp approximation
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'd1073741824;
    // floor(x/6) = (x * RECIP6) >> 20 for x below 2^18
    localparam logic [17:0] RECIP6    = 18'd174763;
    // Largest magnitude of a clamped signed 64-bit value
    localparam logic [62:0] LIM_MAG   = {63{1'b1}};
    // 1.0 in Q16.16
    localparam logic [62:0] ONE_Q16   = 63'd65536;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [2:0]         ang_x;
        logic [2:0]         ang_y;
        logic [2:0]         ang_z;
        logic [31:0]        gauss_exponent;
        logic signed [31:0] contraction_coef;
        logic signed [31:0] orbital_coef;
    } item_t;

    typedef struct packed {
        logic [63:0] density;
        logic        saturated;
    } result_t;

    // One entry of the primitive table
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [2:0]         ang_x;
        logic [2:0]         ang_y;
        logic [2:0]         ang_z;
        logic [31:0]        exponent;
        logic signed [31:0] contraction;
        logic signed [31:0] orbital;
    } prim_t;

    // Multiplier request and response
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } mul_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CUT2,
        ST_FETCH,
        ST_LOAD,
        ST_SQX,
        ST_SQY,
        ST_SQZ,
        ST_ALPHA,
        ST_EXPU,
        ST_EXPS,
        ST_EXPS2,
        ST_EXPS3,
        ST_EXPQ,
        ST_EXPM,
        ST_POW,
        ST_CC,
        ST_T1,
        ST_T2,
        ST_ACC,
        ST_AMP,
        ST_DENS,
        ST_DONE
    } seq_state_t;

    // 2^(-j/16) in Q1.30
    function automatic logic [30:0] pow2_frac(input logic [3:0] j);
        logic [30:0] v;
        begin
            case (j)
                4'd0:    v = 31'd1073741824;
                4'd1:    v = 31'd1028218693;
                4'd2:    v = 31'd984625594;
                4'd3:    v = 31'd942880699;
                4'd4:    v = 31'd902905651;
                4'd5:    v = 31'd864625413;
                4'd6:    v = 31'd827968132;
                4'd7:    v = 31'd792865000;
                4'd8:    v = 31'd759250125;
                4'd9:    v = 31'd727060411;
                4'd10:   v = 31'd696235434;
                4'd11:   v = 31'd666717336;
                4'd12:   v = 31'd638450708;
                4'd13:   v = 31'd611382493;
                4'd14:   v = 31'd585461881;
                default: v = 31'd560640218;
            endcase
            pow2_frac = v;
        end
    endfunction

endpackage

`default_nettype wire

/* src/gaodg_tab.sv */
// Primitive table memory: one write port, one registered read port.
`default_nettype none

module gaodg_tab #(
    parameter int MAX_PRIMITIVES = 256
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [((MAX_PRIMITIVES > 1) ? $clog2(MAX_PRIMITIVES) : 1)-1:0] wr_addr,
    input  gaodg_pkg::prim_t      wr_data,
    input  logic                  rd_en,
    input  logic [((MAX_PRIMITIVES > 1) ? $clog2(MAX_PRIMITIVES) : 1)-1:0] rd_addr,
    output gaodg_pkg::prim_t      rd_data
);
    import gaodg_pkg::*;

    prim_t mem [MAX_PRIMITIVES];
    prim_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/gaodg_mul.sv */
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier, one half pair at a time.
`default_nettype none

module gaodg_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  gaodg_pkg::mul_req_t req,
    output gaodg_pkg::mul_rsp_t rsp
);
    import gaodg_pkg::*;

    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   pp_sh_reg, pp_sh_next;
    logic [2:0]   phase_reg, phase_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  a_half, b_half;

    // Partial product select: phase bit 1 picks the a half, bit 0 the b half
    assign a_half = phase_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = phase_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        pp_next    = pp_reg;
        pp_sh_next = pp_sh_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (busy_reg)
        begin
            // multiply one half pair, accumulate the previous one
            if (phase_reg != 3'd4)
            begin
                pp_next    = a_half * b_half;
                pp_sh_next = {1'b0, phase_reg[1]} + {1'b0, phase_reg[0]};
            end
            if (phase_reg != 3'd0)
            begin
                acc_next = acc_reg + ({64'd0, pp_reg} << {pp_sh_reg, 5'd0});
            end
            if (phase_reg == 3'd4)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            phase_next = phase_reg + 3'd1;
        end
        else if (req.start)
        begin
            a_next     = req.a;
            b_next     = req.b;
            acc_next   = '0;
            phase_next = 3'd0;
            busy_next  = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 3'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    // Operands and accumulator
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

`default_nettype wire

/* src/gaodg_seq.sv */
// Sequencer and datapath registers: walks the primitive table per grid point.
`default_nettype none

module gaodg_seq #(
    parameter int MAX_PRIMITIVES = 256,
    parameter int MAX_ANGULAR    = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  gaodg_pkg::item_t     item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output gaodg_pkg::result_t   result,
    input  logic [31:0]          cutoff,
    output logic                 tab_wr_en,
    output logic [((MAX_PRIMITIVES > 1) ? $clog2(MAX_PRIMITIVES) : 1)-1:0] tab_wr_addr,
    output gaodg_pkg::prim_t     tab_wr_data,
    output logic                 tab_rd_en,
    output logic [((MAX_PRIMITIVES > 1) ? $clog2(MAX_PRIMITIVES) : 1)-1:0] tab_rd_addr,
    input  gaodg_pkg::prim_t     tab_rd_data,
    output gaodg_pkg::mul_req_t  mul_req,
    input  gaodg_pkg::mul_rsp_t  mul_rsp
);
    import gaodg_pkg::*;

    localparam int IDX_W = (MAX_PRIMITIVES > 1) ? $clog2(MAX_PRIMITIVES) : 1;
    localparam int CNT_W = $clog2(MAX_PRIMITIVES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PRIMITIVES);
    localparam logic [3:0] ANG_MAX = 4'(MAX_ANGULAR);
    localparam logic signed [64:0] POS_LIM = {2'b00, LIM_MAG};
    localparam logic signed [64:0] NEG_LIM = -POS_LIM;

    function automatic logic [3:0] clamp_ang(input logic [2:0] a);
        begin
            clamp_ang = ({1'b0, a} > ANG_MAX) ? ANG_MAX : {1'b0, a};
        end
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        begin
            mag32 = v[31] ? (32'd0 - v) : v;
        end
    endfunction

    // Control registers
    seq_state_t       state_reg, state_next;
    logic             issued_reg, issued_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             result_valid_reg, result_valid_next;

    // Datapath registers
    logic signed [31:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [47:0] cut2_reg, cut2_next;
    logic [31:0] dmag_x_reg, dmag_x_next, dmag_y_reg, dmag_y_next, dmag_z_reg, dmag_z_next;
    logic        dneg_x_reg, dneg_x_next, dneg_y_reg, dneg_y_next, dneg_z_reg, dneg_z_next;
    logic [49:0] r2_reg, r2_next;
    logic [21:0] t_reg, t_next;
    logic [6:0]  n_reg, n_next;
    logic [15:0] g_reg, g_next;
    logic [25:0] s_reg, s_next;
    logic [21:0] s2_reg, s2_next;
    logic [17:0] s3_reg, s3_next;
    logic [30:0] poly_reg, poly_next;
    logic [30:0] e_reg, e_next;
    logic [62:0] pre_mag_reg, pre_mag_next;
    logic        pre_neg_reg, pre_neg_next;
    logic [1:0]  axis_reg, axis_next;
    logic [3:0]  pcnt_reg, pcnt_next;
    logic [62:0] cc_mag_reg, cc_mag_next;
    logic        cc_neg_reg, cc_neg_next;
    logic [62:0] t_mag_reg, t_mag_next;
    logic        t_neg_reg, t_neg_next;
    logic signed [63:0] sum_reg, sum_next;
    logic        sat_reg, sat_next;
    logic [31:0] amp_reg, amp_next;
    logic [63:0] dens_reg, dens_next;
    result_t     result_reg, result_next;

    // Helpers
    logic         accept;
    logic         mul_state;
    logic         mul_done;
    logic [127:0] p;
    logic         sat16, sat30;
    logic [62:0]  val16, val30;
    logic [49:0]  r2_total;
    logic         cut_skip;
    logic         alpha_skip;
    logic [CNT_W-1:0] idx_inc;
    logic         last;
    seq_state_t   skip_dest;
    logic [32:0]  diff_x, diff_y, diff_z;
    logic [31:0]  dmag_axis;
    logic         dneg_axis;
    logic [2:0]   ang_next_axis;
    logic [31:0]  poly_full;
    logic [63:0]  term64;
    logic signed [64:0] sum65;
    logic [63:0]  sum_abs;
    logic [38:0]  amp_wide;
    logic         amp_ovf;
    logic         out_free;

    assign accept   = item_valid && !item_stall;
    assign mul_done = mul_rsp.done;
    assign p        = mul_rsp.prod;

    // Clamped product shifts
    assign sat16 = |p[127:79];
    assign val16 = sat16 ? LIM_MAG : p[78:16];
    assign sat30 = |p[127:93];
    assign val30 = sat30 ? LIM_MAG : p[92:30];

    // Cutoff and exponent range tests
    assign r2_total   = r2_reg + {2'b00, p[63:16]};
    assign cut_skip   = (cutoff != 32'd0) && (r2_total >= {2'b00, cut2_reg});
    assign alpha_skip = |p[127:38];

    // Primitive walk
    assign idx_inc   = CNT_W'(idx_reg + 1'b1);
    assign last      = (idx_inc == count_reg);
    assign skip_dest = last ? ST_AMP : ST_FETCH;

    // Point minus center, exact in 33 bits
    assign diff_x = {px_reg[31], px_reg} - {tab_rd_data.center_x[31], tab_rd_data.center_x};
    assign diff_y = {py_reg[31], py_reg} - {tab_rd_data.center_y[31], tab_rd_data.center_y};
    assign diff_z = {pz_reg[31], pz_reg} - {tab_rd_data.center_z[31], tab_rd_data.center_z};

    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                dmag_axis     = dmag_x_reg;
                dneg_axis     = dneg_x_reg;
                ang_next_axis = tab_rd_data.ang_y;
            end
            2'd1:
            begin
                dmag_axis     = dmag_y_reg;
                dneg_axis     = dneg_y_reg;
                ang_next_axis = tab_rd_data.ang_z;
            end
            default:
            begin
                dmag_axis     = dmag_z_reg;
                dneg_axis     = dneg_z_reg;
                ang_next_axis = tab_rd_data.ang_z;
            end
        endcase
    end

    // 1 - s + s^2/2 - s^3/6; p holds s3 * RECIP6 in the quotient step
    assign poly_full = 32'(ONE_Q30) - 32'(s_reg) + 32'(s2_reg >> 1) - 32'(p[37:20]);

    // Saturating accumulate
    assign term64 = t_neg_reg ? (64'd0 - {1'b0, t_mag_reg}) : {1'b0, t_mag_reg};
    assign sum65  = $signed({sum_reg[63], sum_reg}) + $signed({term64[63], term64});

    // Final amplitude
    assign sum_abs  = sum_reg[63] ? (64'd0 - sum_reg) : sum_reg;
    assign amp_wide = sum_abs[62:24];
    assign amp_ovf  = |amp_wide[38:32];

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        case (state_reg) inside
            ST_CUT2, ST_SQX, ST_SQY, ST_SQZ, ST_ALPHA, ST_EXPU, ST_EXPS, ST_EXPS2,
            ST_EXPS3, ST_EXPQ, ST_EXPM, ST_POW, ST_CC, ST_T1, ST_T2, ST_DENS:
                mul_state = 1'b1;
            default:
                mul_state = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && item.opcode == OP_EVAL)
                begin
                    state_next = ST_CUT2;
                end
            ST_CUT2:
                if (mul_done)
                begin
                    state_next = (count_reg == '0) ? ST_AMP : ST_FETCH;
                end
            ST_FETCH:
                state_next = ST_LOAD;
            ST_LOAD:
                state_next = ST_SQX;
            ST_SQX:
                if (mul_done)
                begin
                    state_next = ST_SQY;
                end
            ST_SQY:
                if (mul_done)
                begin
                    state_next = ST_SQZ;
                end
            ST_SQZ:
                if (mul_done)
                begin
                    state_next = cut_skip ? skip_dest : ST_ALPHA;
                end
            ST_ALPHA:
                if (mul_done)
                begin
                    state_next = alpha_skip ? skip_dest : ST_EXPU;
                end
            ST_EXPU:
                if (mul_done)
                begin
                    state_next = (p[52:46] > 7'd30) ? ST_POW : ST_EXPS;
                end
            ST_EXPS:
                if (mul_done)
                begin
                    state_next = ST_EXPS2;
                end
            ST_EXPS2:
                if (mul_done)
                begin
                    state_next = ST_EXPS3;
                end
            ST_EXPS3:
                if (mul_done)
                begin
                    state_next = ST_EXPQ;
                end
            ST_EXPQ:
                if (mul_done)
                begin
                    state_next = ST_EXPM;
                end
            ST_EXPM:
                if (mul_done)
                begin
                    state_next = ST_POW;
                end
            ST_POW:
                if (pcnt_reg == 4'd0 && axis_reg == 2'd2)
                begin
                    state_next = ST_CC;
                end
            ST_CC:
                if (mul_done)
                begin
                    state_next = ST_T1;
                end
            ST_T1:
                if (mul_done)
                begin
                    state_next = ST_T2;
                end
            ST_T2:
                if (mul_done)
                begin
                    state_next = ST_ACC;
                end
            ST_ACC:
                state_next = skip_dest;
            ST_AMP:
                state_next = amp_ovf ? ST_DONE : ST_DENS;
            ST_DENS:
                if (mul_done)
                begin
                    state_next = ST_DONE;
                end
            ST_DONE:
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, table ports, multiplier request
    always_comb
    begin
        item_stall  = (state_reg != ST_IDLE);
        tab_wr_en   = accept && (item.opcode == OP_APPEND) && (count_reg < CNT_MAX);
        tab_wr_addr = count_reg[IDX_W-1:0];
        tab_wr_data.center_x    = item.pos_x;
        tab_wr_data.center_y    = item.pos_y;
        tab_wr_data.center_z    = item.pos_z;
        tab_wr_data.ang_x       = item.ang_x;
        tab_wr_data.ang_y       = item.ang_y;
        tab_wr_data.ang_z       = item.ang_z;
        tab_wr_data.exponent    = item.gauss_exponent;
        tab_wr_data.contraction = item.contraction_coef;
        tab_wr_data.orbital     = item.orbital_coef;
        tab_rd_en   = (state_reg == ST_FETCH);
        tab_rd_addr = idx_reg[IDX_W-1:0];
        mul_req.start = mul_state && !issued_reg
                        && !(state_reg == ST_POW && pcnt_reg == 4'd0);
        unique case (state_reg)
            ST_CUT2:
            begin
                mul_req.a = 64'(cutoff);
                mul_req.b = 64'(cutoff);
            end
            ST_SQX:
            begin
                mul_req.a = 64'(dmag_x_reg);
                mul_req.b = 64'(dmag_x_reg);
            end
            ST_SQY:
            begin
                mul_req.a = 64'(dmag_y_reg);
                mul_req.b = 64'(dmag_y_reg);
            end
            ST_SQZ:
            begin
                mul_req.a = 64'(dmag_z_reg);
                mul_req.b = 64'(dmag_z_reg);
            end
            ST_ALPHA:
            begin
                mul_req.a = 64'(tab_rd_data.exponent);
                mul_req.b = 64'(r2_reg);
            end
            ST_EXPU:
            begin
                mul_req.a = 64'(t_reg);
                mul_req.b = 64'(LOG2E_Q30);
            end
            ST_EXPS:
            begin
                mul_req.a = 64'(g_reg[11:0]);
                mul_req.b = 64'(LN2_Q30);
            end
            ST_EXPS2:
            begin
                mul_req.a = 64'(s_reg);
                mul_req.b = 64'(s_reg);
            end
            ST_EXPS3:
            begin
                mul_req.a = 64'(s2_reg);
                mul_req.b = 64'(s_reg);
            end
            ST_EXPQ:
            begin
                mul_req.a = 64'(s3_reg);
                mul_req.b = 64'(RECIP6);
            end
            ST_EXPM:
            begin
                mul_req.a = 64'(pow2_frac(g_reg[15:12]));
                mul_req.b = 64'(poly_reg);
            end
            ST_POW:
            begin
                mul_req.a = 64'(pre_mag_reg);
                mul_req.b = 64'(dmag_axis);
            end
            ST_CC:
            begin
                mul_req.a = 64'(mag32(tab_rd_data.contraction));
                mul_req.b = 64'(mag32(tab_rd_data.orbital));
            end
            ST_T1:
            begin
                mul_req.a = 64'(cc_mag_reg);
                mul_req.b = 64'(pre_mag_reg);
            end
            ST_T2:
            begin
                mul_req.a = 64'(t_mag_reg);
                mul_req.b = 64'(e_reg);
            end
            ST_DENS:
            begin
                mul_req.a = 64'(amp_reg);
                mul_req.b = 64'(amp_reg);
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
        result_valid = result_valid_reg;
        result       = result_reg;
    end

    // Register updates
    always_comb
    begin
        issued_next  = issued_reg ? !mul_done : mul_req.start;
        count_next   = count_reg;
        idx_next     = idx_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        pz_next      = pz_reg;
        cut2_next    = cut2_reg;
        dmag_x_next  = dmag_x_reg;
        dmag_y_next  = dmag_y_reg;
        dmag_z_next  = dmag_z_reg;
        dneg_x_next  = dneg_x_reg;
        dneg_y_next  = dneg_y_reg;
        dneg_z_next  = dneg_z_reg;
        r2_next      = r2_reg;
        t_next       = t_reg;
        n_next       = n_reg;
        g_next       = g_reg;
        s_next       = s_reg;
        s2_next      = s2_reg;
        s3_next      = s3_reg;
        poly_next    = poly_reg;
        e_next       = e_reg;
        pre_mag_next = pre_mag_reg;
        pre_neg_next = pre_neg_reg;
        axis_next    = axis_reg;
        pcnt_next    = pcnt_reg;
        cc_mag_next  = cc_mag_reg;
        cc_neg_next  = cc_neg_reg;
        t_mag_next   = t_mag_reg;
        t_neg_next   = t_neg_reg;
        sum_next     = sum_reg;
        sat_next     = sat_reg;
        amp_next     = amp_reg;
        dens_next    = dens_reg;
        result_next  = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    unique case (item.opcode)
                        OP_CLEAR:
                            count_next = '0;
                        OP_APPEND:
                            if (count_reg < CNT_MAX)
                            begin
                                count_next = CNT_W'(count_reg + 1'b1);
                            end
                        OP_EVAL:
                        begin
                            px_next  = item.pos_x;
                            py_next  = item.pos_y;
                            pz_next  = item.pos_z;
                            idx_next = '0;
                            sum_next = '0;
                            sat_next = 1'b0;
                        end
                        default:
                            ;
                    endcase
                end
            ST_CUT2:
                if (mul_done)
                begin
                    cut2_next = p[63:16];
                end
            ST_LOAD:
            begin
                dneg_x_next = diff_x[32];
                dneg_y_next = diff_y[32];
                dneg_z_next = diff_z[32];
                dmag_x_next = diff_x[32] ? 32'(33'd0 - diff_x) : diff_x[31:0];
                dmag_y_next = diff_y[32] ? 32'(33'd0 - diff_y) : diff_y[31:0];
                dmag_z_next = diff_z[32] ? 32'(33'd0 - diff_z) : diff_z[31:0];
            end
            ST_SQX:
                if (mul_done)
                begin
                    r2_next = {2'b00, p[63:16]};
                end
            ST_SQY:
                if (mul_done)
                begin
                    r2_next = r2_total;
                end
            ST_SQZ:
                if (mul_done)
                begin
                    r2_next = r2_total;
                    if (cut_skip)
                    begin
                        idx_next = idx_inc;
                    end
                end
            ST_ALPHA:
                if (mul_done)
                begin
                    t_next = p[37:16];
                    if (alpha_skip)
                    begin
                        idx_next = idx_inc;
                    end
                end
            ST_EXPU:
                if (mul_done)
                begin
                    n_next = p[52:46];
                    g_next = p[45:30];
                    if (p[52:46] > 7'd30)
                    begin
                        // factor underflows to zero
                        e_next       = '0;
                        pre_mag_next = ONE_Q16;
                        pre_neg_next = 1'b0;
                        axis_next    = 2'd0;
                        pcnt_next    = clamp_ang(tab_rd_data.ang_x);
                    end
                end
            ST_EXPS:
                if (mul_done)
                begin
                    s_next = p[41:16];
                end
            ST_EXPS2:
                if (mul_done)
                begin
                    s2_next = p[51:30];
                end
            ST_EXPS3:
                if (mul_done)
                begin
                    s3_next = p[47:30];
                end
            ST_EXPQ:
                if (mul_done)
                begin
                    poly_next = poly_full[30:0];
                end
            ST_EXPM:
                if (mul_done)
                begin
                    e_next       = p[60:30] >> n_reg;
                    pre_mag_next = ONE_Q16;
                    pre_neg_next = 1'b0;
                    axis_next    = 2'd0;
                    pcnt_next    = clamp_ang(tab_rd_data.ang_x);
                end
            ST_POW:
                if (pcnt_reg == 4'd0)
                begin
                    if (axis_reg != 2'd2)
                    begin
                        axis_next = axis_reg + 2'd1;
                        pcnt_next = clamp_ang(ang_next_axis);
                    end
                end
                else if (mul_done)
                begin
                    pre_mag_next = val16;
                    pre_neg_next = (val16 != '0) && (pre_neg_reg != dneg_axis);
                    sat_next     = sat_reg || sat16;
                    pcnt_next    = pcnt_reg - 4'd1;
                end
            ST_CC:
                if (mul_done)
                begin
                    cc_mag_next = {8'd0, p[62:8]};
                    cc_neg_next = (p[62:8] != '0)
                                  && (tab_rd_data.contraction[31] != tab_rd_data.orbital[31]);
                end
            ST_T1:
                if (mul_done)
                begin
                    t_mag_next = val16;
                    t_neg_next = (val16 != '0) && (cc_neg_reg != pre_neg_reg);
                    sat_next   = sat_reg || sat16;
                end
            ST_T2:
                if (mul_done)
                begin
                    t_mag_next = val30;
                    t_neg_next = (val30 != '0) && t_neg_reg;
                    sat_next   = sat_reg || sat30;
                end
            ST_ACC:
            begin
                idx_next = idx_inc;
                if (sum65 > POS_LIM)
                begin
                    sum_next = {1'b0, LIM_MAG};
                    sat_next = 1'b1;
                end
                else if (sum65 < NEG_LIM)
                begin
                    sum_next = 64'd0 - {1'b0, LIM_MAG};
                    sat_next = 1'b1;
                end
                else
                begin
                    sum_next = sum65[63:0];
                end
            end
            ST_AMP:
            begin
                amp_next = amp_wide[31:0];
                if (amp_ovf)
                begin
                    dens_next = '1;
                    sat_next  = 1'b1;
                end
            end
            ST_DENS:
                if (mul_done)
                begin
                    dens_next = p[63:0];
                end
            ST_DONE:
                if (out_free)
                begin
                    result_next.density   = dens_reg;
                    result_next.saturated = sat_reg;
                    result_valid_next     = 1'b1;
                end
            default:
                ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issued_reg       <= 1'b0;
            count_reg        <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            issued_reg       <= issued_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        pz_reg      <= pz_next;
        cut2_reg    <= cut2_next;
        dmag_x_reg  <= dmag_x_next;
        dmag_y_reg  <= dmag_y_next;
        dmag_z_reg  <= dmag_z_next;
        dneg_x_reg  <= dneg_x_next;
        dneg_y_reg  <= dneg_y_next;
        dneg_z_reg  <= dneg_z_next;
        r2_reg      <= r2_next;
        t_reg       <= t_next;
        n_reg       <= n_next;
        g_reg       <= g_next;
        s_reg       <= s_next;
        s2_reg      <= s2_next;
        s3_reg      <= s3_next;
        poly_reg    <= poly_next;
        e_reg       <= e_next;
        pre_mag_reg <= pre_mag_next;
        pre_neg_reg <= pre_neg_next;
        axis_reg    <= axis_next;
        pcnt_reg    <= pcnt_next;
        cc_mag_reg  <= cc_mag_next;
        cc_neg_reg  <= cc_neg_next;
        t_mag_reg   <= t_mag_next;
        t_neg_reg   <= t_neg_next;
        sum_reg     <= sum_next;
        sat_reg     <= sat_next;
        amp_reg     <= amp_next;
        dens_reg    <= dens_next;
        result_reg  <= result_next;
    end

endmodule

`default_nettype wire

/* src/gaussian_orbital_density_grid.sv */
// Top level: cutoff register, primitive table, shared multiplier and sequencer.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  item     | in        | item_valid/item_stall  | item (opcode, point/primitive)
//  result   | out       | result_valid/result_stall | result (density, saturated)
//  cfg      | in        | cfg_we                 | cfg_data (cutoff, Q16.16)
//
// Clear, append and ignored items are taken in the idle state. An evaluate item
// runs every multiply on the one 64x64 unit: it takes the point and squares the
// cutoff, then works through each primitive in turn (the cutoff test or the
// exponent test can drop one early), then squares the amplitude and loads the
// output register (the square is skipped when the amplitude overflows). The
// result waits in an output register; the next item is taken while it waits,
// and a second result holds the sequencer until the first is taken. Reset
// clears the count and the cutoff; table contents are not cleared.
`default_nettype none

module gaussian_orbital_density_grid #(
    parameter int MAX_PRIMITIVES = 256,
    parameter int MAX_ANGULAR    = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  gaodg_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output gaodg_pkg::result_t result,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data
);
    import gaodg_pkg::*;

    localparam int IDX_W = (MAX_PRIMITIVES > 1) ? $clog2(MAX_PRIMITIVES) : 1;

    logic [31:0] cutoff_reg, cutoff_next;
    logic        tab_wr_en, tab_rd_en;
    logic [IDX_W-1:0] tab_wr_addr, tab_rd_addr;
    prim_t       tab_wr_data, tab_rd_data;
    mul_req_t    mul_req;
    mul_rsp_t    mul_rsp;

    // Cutoff register
    always_comb
    begin
        cutoff_next = cfg_we ? cfg_data : cutoff_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= '0;
        end
        else
        begin
            cutoff_reg <= cutoff_next;
        end
    end

    gaodg_tab #(
        .MAX_PRIMITIVES(MAX_PRIMITIVES)
    ) u_tab (
        .clk     (clk),
        .wr_en   (tab_wr_en),
        .wr_addr (tab_wr_addr),
        .wr_data (tab_wr_data),
        .rd_en   (tab_rd_en),
        .rd_addr (tab_rd_addr),
        .rd_data (tab_rd_data)
    );

    gaodg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    gaodg_seq #(
        .MAX_PRIMITIVES(MAX_PRIMITIVES),
        .MAX_ANGULAR   (MAX_ANGULAR)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cutoff       (cutoff_reg),
        .tab_wr_en    (tab_wr_en),
        .tab_wr_addr  (tab_wr_addr),
        .tab_wr_data  (tab_wr_data),
        .tab_rd_en    (tab_rd_en),
        .tab_rd_addr  (tab_rd_addr),
        .tab_rd_data  (tab_rd_data),
        .mul_req      (mul_req),
        .mul_rsp      (mul_rsp)
    );

endmodule

`default_nettype wire
